[hdl/fpd_pkg.sv]
// ============================================================================
// fpd_pkg
// Types and constants shared by the flight phase detector.
// ============================================================================
package fpd_pkg;

    typedef enum logic [2:0] {
        PH_PREFLIGHT = 3'd0,
        PH_POWERED   = 3'd1,
        PH_COASTING  = 3'd2,
        PH_DESCENT   = 3'd3,
        PH_LANDED    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_LAUNCH  = 3'd1,
        EV_BURNOUT = 3'd2,
        EV_APOGEE  = 3'd3,
        EV_LANDING = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        REG_LAUNCH_ALT    = 3'd0,
        REG_LAUNCH_VEL    = 3'd1,
        REG_BURNOUT_ACCEL = 3'd2,
        REG_BURNOUT_VEL   = 3'd3,
        REG_APOGEE_MIN    = 3'd4,
        REG_APOGEE_COUNT  = 3'd5,
        REG_LAND_ALT      = 3'd6,
        REG_PYRO_HOLD     = 3'd7
    } reg_idx_t;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam int PADDR_W = 5;

    localparam logic signed [21:0] GRAVITY_MMS2    = 22'sd9807;
    localparam logic signed [17:0] DESCENT_VEL_CMS = -18'sd50;
    localparam logic signed [17:0] LAND_VEL_CMS    = 18'sd100;
    localparam logic [3:0]         DESCENT_SAT     = 4'd15;

    typedef struct packed {
        logic [16:0] launch_alt_cm;
        logic [16:0] launch_vel_cms;
        logic [18:0] burnout_accel_mms2;
        logic [16:0] burnout_vel_cms;
        logic [19:0] apogee_min_alt_cm;
        logic [3:0]  apogee_confirm_count;
        logic [19:0] land_alt_cm;
        logic [15:0] pyro_hold_ms;
    } cfg_t;

endpackage

[hdl/fpd_tick_if.sv]
// ============================================================================
// fpd_tick_if
// Input channel: one sensor tick or start command per transaction.
// ============================================================================
interface fpd_tick_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [24:0] altitude_cm;
    logic signed [17:0] vel_up_cms;
    logic signed [19:0] accel_z_mms2;
    logic signed [16:0] accel_bias_mms2;
    logic [31:0]        now_ms;

    modport source (
        output valid, action, altitude_cm, vel_up_cms, accel_z_mms2,
               accel_bias_mms2, now_ms,
        input  ready
    );

    modport sink (
        input  valid, action, altitude_cm, vel_up_cms, accel_z_mms2,
               accel_bias_mms2, now_ms,
        output ready
    );
endinterface

[hdl/fpd_result_if.sv]
// ============================================================================
// fpd_result_if
// Output channel: phase, event code and pyro level per transaction.
// ============================================================================
interface fpd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic [2:0] event_code;
    logic       pyro_on;

    modport source (
        output valid, phase, event_code, pyro_on,
        input  ready
    );

    modport sink (
        input  valid, phase, event_code, pyro_on,
        output ready
    );
endinterface

[hdl/flight_phase_detector.sv]
// ============================================================================
// flight_phase_detector
// Tracks rocket flight phase from fused sensor ticks and fires the apogee pyro.
// ============================================================================
//  channel  dir  kind        content
//  -------  ---  ----------  ---------------------------------------------
//  tick     in   valid/ready action, altitude, velocity, accel, bias, time
//  result   out  valid/ready phase, event code, pyro level
//  apb      io   APB r/w     eight threshold/timing registers at 4*i
//
//  One transaction per cycle while result.ready stays high; an accepted
//  tick goes into the input register, then through the phase logic into
//  the result register, where the result is valid.
//  While a result waits for ready the input register takes one more tick,
//  then tick.ready drops until the result is taken.
//  Reset clears phase, descent count, pyro state and loads register defaults.
// ============================================================================
module flight_phase_detector (
    input  logic                         clk,
    input  logic                         rst_n,
    fpd_tick_if.sink                     tick,
    fpd_result_if.source                 result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    fpd_pkg::cfg_t cfg;

    fpd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic               s1_valid_reg;
    logic               s1_action_reg;
    logic signed [24:0] s1_alt_reg;
    logic signed [17:0] s1_vel_reg;
    logic signed [19:0] s1_az_reg;
    logic signed [16:0] s1_bias_reg;
    logic [31:0]        s1_now_reg;

    // flight state
    fpd_pkg::phase_t    phase_reg, phase_next;
    logic [3:0]         descent_reg, descent_next;
    logic               pyro_active_reg, pyro_active_next;
    logic [31:0]        pyro_start_reg, pyro_start_next;

    // result register
    logic               res_valid_reg;
    fpd_pkg::phase_t    res_phase_reg;
    fpd_pkg::event_t    res_event_reg;
    logic               res_pyro_reg;
    fpd_pkg::event_t    event_next;

    logic tick_fire;
    logic out_free;
    logic advance;

    assign out_free   = !res_valid_reg || result.ready;
    assign advance    = s1_valid_reg && out_free;
    assign tick.ready = !s1_valid_reg || out_free;
    assign tick_fire  = tick.valid && tick.ready;

    // condition logic
    logic signed [21:0] net_accel;
    logic [21:0]        net_accel_abs;
    logic [31:0]        pyro_elapsed;
    logic               pyro_expired;
    logic               launch_hit;
    logic               burnout_hit;
    logic               descent_hit;
    logic [3:0]         ticks_inc;
    logic               apogee_hit;
    logic               land_hit;

    assign net_accel     = 22'(s1_az_reg) - 22'(s1_bias_reg) - fpd_pkg::GRAVITY_MMS2;
    assign net_accel_abs = net_accel[21] ? 22'(-net_accel) : 22'(net_accel);
    assign pyro_elapsed  = s1_now_reg - pyro_start_reg;
    assign pyro_expired  = pyro_active_reg && (pyro_elapsed > {16'd0, cfg.pyro_hold_ms});

    assign launch_hit  = (s1_alt_reg > $signed({8'd0, cfg.launch_alt_cm}))
                      || (s1_vel_reg > $signed({1'b0, cfg.launch_vel_cms}));
    assign burnout_hit = (net_accel_abs < {3'd0, cfg.burnout_accel_mms2})
                      && (s1_vel_reg > $signed({1'b0, cfg.burnout_vel_cms}));
    assign descent_hit = (s1_vel_reg < fpd_pkg::DESCENT_VEL_CMS)
                      && (s1_alt_reg > $signed({5'd0, cfg.apogee_min_alt_cm}));
    assign ticks_inc   = (descent_reg == fpd_pkg::DESCENT_SAT) ? descent_reg
                                                               : descent_reg + 4'd1;
    assign apogee_hit  = descent_hit && (ticks_inc >= cfg.apogee_confirm_count);
    assign land_hit    = (s1_alt_reg < $signed({5'd0, cfg.land_alt_cm}))
                      && (s1_vel_reg < fpd_pkg::LAND_VEL_CMS)
                      && (s1_vel_reg > -fpd_pkg::LAND_VEL_CMS);

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        descent_next     = descent_reg;
        pyro_active_next = pyro_active_reg;
        pyro_start_next  = pyro_start_reg;
        if (s1_action_reg == fpd_pkg::ACT_START)
        begin
            phase_next   = fpd_pkg::PH_PREFLIGHT;
            descent_next = 4'd0;
        end
        else
        begin
            if (pyro_expired)
            begin
                pyro_active_next = 1'b0;
            end
            unique case (phase_reg)
                fpd_pkg::PH_PREFLIGHT:
                begin
                    if (launch_hit)
                    begin
                        phase_next = fpd_pkg::PH_POWERED;
                    end
                end
                fpd_pkg::PH_POWERED:
                begin
                    if (burnout_hit)
                    begin
                        phase_next = fpd_pkg::PH_COASTING;
                    end
                end
                fpd_pkg::PH_COASTING:
                begin
                    if (apogee_hit)
                    begin
                        phase_next       = fpd_pkg::PH_DESCENT;
                        pyro_active_next = 1'b1;
                        pyro_start_next  = s1_now_reg;
                        descent_next     = 4'd0;
                    end
                    else if (descent_hit)
                    begin
                        descent_next = ticks_inc;
                    end
                    else
                    begin
                        descent_next = 4'd0;
                    end
                end
                fpd_pkg::PH_DESCENT:
                begin
                    if (land_hit)
                    begin
                        phase_next = fpd_pkg::PH_LANDED;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // event output
    always_comb
    begin
        event_next = fpd_pkg::EV_NONE;
        if (s1_action_reg == fpd_pkg::ACT_TICK)
        begin
            unique case (phase_reg)
                fpd_pkg::PH_PREFLIGHT:
                    event_next = launch_hit ? fpd_pkg::EV_LAUNCH : fpd_pkg::EV_NONE;
                fpd_pkg::PH_POWERED:
                    event_next = burnout_hit ? fpd_pkg::EV_BURNOUT : fpd_pkg::EV_NONE;
                fpd_pkg::PH_COASTING:
                    event_next = apogee_hit ? fpd_pkg::EV_APOGEE : fpd_pkg::EV_NONE;
                fpd_pkg::PH_DESCENT:
                    event_next = land_hit ? fpd_pkg::EV_LANDING : fpd_pkg::EV_NONE;
                default:
                    event_next = fpd_pkg::EV_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            phase_reg       <= fpd_pkg::PH_PREFLIGHT;
            descent_reg     <= 4'd0;
            pyro_active_reg <= 1'b0;
            pyro_start_reg  <= 32'd0;
        end
        else
        begin
            if (tick_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                descent_reg     <= descent_next;
                pyro_active_reg <= pyro_active_next;
                pyro_start_reg  <= pyro_start_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            s1_action_reg <= tick.action;
            s1_alt_reg    <= tick.altitude_cm;
            s1_vel_reg    <= tick.vel_up_cms;
            s1_az_reg     <= tick.accel_z_mms2;
            s1_bias_reg   <= tick.accel_bias_mms2;
            s1_now_reg    <= tick.now_ms;
        end
        if (advance)
        begin
            res_phase_reg <= phase_next;
            res_event_reg <= event_next;
            res_pyro_reg  <= pyro_active_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.phase      = res_phase_reg;
    assign result.event_code = res_event_reg;
    assign result.pyro_on    = res_pyro_reg;

endmodule

[hdl/fpd_cfg_regs.sv]
// ============================================================================
// fpd_cfg_regs
// APB register file holding the detector thresholds and pyro hold time.
// ============================================================================
module fpd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output fpd_pkg::cfg_t                cfg
);

    fpd_pkg::cfg_t    cfg_reg;
    fpd_pkg::cfg_t    cfg_next;
    fpd_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = fpd_pkg::reg_idx_t'(paddr[fpd_pkg::PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                fpd_pkg::REG_LAUNCH_ALT:    cfg_next.launch_alt_cm        = pwdata[16:0];
                fpd_pkg::REG_LAUNCH_VEL:    cfg_next.launch_vel_cms       = pwdata[16:0];
                fpd_pkg::REG_BURNOUT_ACCEL: cfg_next.burnout_accel_mms2   = pwdata[18:0];
                fpd_pkg::REG_BURNOUT_VEL:   cfg_next.burnout_vel_cms      = pwdata[16:0];
                fpd_pkg::REG_APOGEE_MIN:    cfg_next.apogee_min_alt_cm    = pwdata[19:0];
                fpd_pkg::REG_APOGEE_COUNT:  cfg_next.apogee_confirm_count = pwdata[3:0];
                fpd_pkg::REG_LAND_ALT:      cfg_next.land_alt_cm          = pwdata[19:0];
                fpd_pkg::REG_PYRO_HOLD:     cfg_next.pyro_hold_ms         = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            fpd_pkg::REG_LAUNCH_ALT:    prdata = {15'd0, cfg_reg.launch_alt_cm};
            fpd_pkg::REG_LAUNCH_VEL:    prdata = {15'd0, cfg_reg.launch_vel_cms};
            fpd_pkg::REG_BURNOUT_ACCEL: prdata = {13'd0, cfg_reg.burnout_accel_mms2};
            fpd_pkg::REG_BURNOUT_VEL:   prdata = {15'd0, cfg_reg.burnout_vel_cms};
            fpd_pkg::REG_APOGEE_MIN:    prdata = {12'd0, cfg_reg.apogee_min_alt_cm};
            fpd_pkg::REG_APOGEE_COUNT:  prdata = {28'd0, cfg_reg.apogee_confirm_count};
            fpd_pkg::REG_LAND_ALT:      prdata = {12'd0, cfg_reg.land_alt_cm};
            fpd_pkg::REG_PYRO_HOLD:     prdata = {16'd0, cfg_reg.pyro_hold_ms};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.launch_alt_cm        <= 17'd500;
            cfg_reg.launch_vel_cms       <= 17'd500;
            cfg_reg.burnout_accel_mms2   <= 19'd2000;
            cfg_reg.burnout_vel_cms      <= 17'd1000;
            cfg_reg.apogee_min_alt_cm    <= 20'd1500;
            cfg_reg.apogee_confirm_count <= 4'd3;
            cfg_reg.land_alt_cm          <= 20'd1000;
            cfg_reg.pyro_hold_ms         <= 16'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/fpd_checker.sv]
// ============================================================================
// fpd_checker
// Port-level checks on the result channel of the flight phase detector.
// ============================================================================
module fpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] res_phase,
    input logic [2:0] res_event,
    input logic       res_pyro
);

    // stalled transaction keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(res_phase) && $stable(res_event) && $stable(res_pyro))
        else $error("result payload changed while stalled");

    a_launch_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_event == fpd_pkg::EV_LAUNCH |-> res_phase == fpd_pkg::PH_POWERED)
        else $error("launch event without powered phase");

    // each event code equals the code of the phase it enters
    a_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_event == fpd_pkg::EV_BURNOUT || res_event == fpd_pkg::EV_APOGEE
                      || res_event == fpd_pkg::EV_LANDING)
        |-> res_phase == res_event)
        else $error("event code does not match phase");

    a_apogee_pyro: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_event == fpd_pkg::EV_APOGEE |-> res_pyro)
        else $error("apogee event without pyro drive");

endmodule

bind flight_phase_detector fpd_checker u_fpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_phase (result.phase),
    .res_event (result.event_code),
    .res_pyro  (result.pyro_on)
);
